// ----- rtl/core/ultrasonic_distance_filter_unit_assert.svh -----
// Assertion macros shared by the distance filter RTL.
`ifndef ULTRASONIC_DISTANCE_FILTER_UNIT_ASSERT_SVH
`define ULTRASONIC_DISTANCE_FILTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UDF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("distance filter check failed");
`define UDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("distance filter sequence check failed");
`else
`define UDF_ASSERT_IMP(label, clk, rst, ante, cons)
`define UDF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/udf_pkg.sv -----
// Shared types and constants of the ultrasonic distance filter.
package udf_pkg;

  localparam int BYTE_W     = 8;
  localparam int DIST_W     = 14;
  localparam int HEIGHT_W   = 14;
  localparam int OFFSET_W   = 9;
  localparam int SPIKE_W    = 14;
  localparam int HOLDOFF_W  = 8;
  localparam int STATUS_W   = 2;
  localparam int UPPER_W    = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 14;

  localparam int MEDIAN_DEPTH_DEF = 7;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;
  localparam int RANGE_MARGIN = 500;
  localparam int UPPER_CAP    = 16380;
  localparam int ROUND_STEP   = 10;
  localparam int RECIP_MUL    = 52429;
  localparam int RECIP_SHIFT  = 19;
  localparam int PROD_W       = 31;

  localparam logic [HEIGHT_W-1:0]  HEIGHT_RST  = 14'd1000;
  localparam logic [OFFSET_W-1:0]  OFFSET_RST  = 9'd30;
  localparam logic [SPIKE_W-1:0]   SPIKE_RST   = 14'd100;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TANK_HEIGHT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_OFFSET = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_MAX     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_HOLDOFF = 8'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SPIKE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CSUM  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic              valid;
    logic              csum_ok;
    logic              range_ok;
    logic [DIST_W-1:0] distance;
  } frm_res_t;

endpackage

// ----- rtl/core/udf_frame.sv -----
// Frame assembler with checksum and plausible range check.
module udf_frame (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  input  logic [udf_pkg::BYTE_W-1:0]      rx_byte,
  input  logic [udf_pkg::HEIGHT_W-1:0]    tank_height,
  input  logic [udf_pkg::OFFSET_W-1:0]    sensor_offset,
  output udf_pkg::frm_res_t               frm
);
  import udf_pkg::*;

  typedef enum logic [1:0] {P_HEADER, P_DATA_H, P_DATA_L, P_SUM} pos_t;

  pos_t                  pos;
  logic [BYTE_W-1:0]     data_h;
  logic [BYTE_W-1:0]     data_l;
  logic [BYTE_W-1:0]     sum;
  logic [2*BYTE_W-1:0]   dist_raw;
  logic [UPPER_W-1:0]    upper_raw;
  logic [UPPER_W-1:0]    upper;
  logic                  range_ok;

  always_comb begin
    sum       = HEADER_BYTE + data_h + data_l;
    dist_raw  = {data_h, data_l};
    upper_raw = UPPER_W'(tank_height) + UPPER_W'(sensor_offset) +
                UPPER_W'(RANGE_MARGIN);
    upper     = (upper_raw > UPPER_W'(UPPER_CAP)) ? UPPER_W'(UPPER_CAP) : upper_raw;
    range_ok  = (dist_raw >= (2*BYTE_W)'(sensor_offset)) &&
                (dist_raw <= (2*BYTE_W)'(upper));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= P_HEADER;
      frm.valid <= 1'b0;
    end else begin
      frm.valid <= 1'b0;
      if (byte_valid) begin
        unique case (pos)
          P_HEADER: begin
            if (rx_byte == HEADER_BYTE) begin
              pos <= P_DATA_H;
            end
          end
          P_DATA_H: begin
            data_h <= rx_byte;
            pos    <= P_DATA_L;
          end
          P_DATA_L: begin
            data_l <= rx_byte;
            pos    <= P_SUM;
          end
          P_SUM: begin
            frm.valid    <= 1'b1;
            frm.csum_ok  <= (rx_byte == sum);
            frm.range_ok <= range_ok;
            frm.distance <= dist_raw[DIST_W-1:0];
            pos          <= P_HEADER;
          end
          default: pos <= P_HEADER;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/udf_median.sv -----
// Circular sample window and median search with one shared comparator.
`include "ultrasonic_distance_filter_unit_assert.svh"
module udf_median #(
  parameter int MEDIAN_DEPTH = udf_pkg::MEDIAN_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [udf_pkg::DIST_W-1:0] din,
  output logic                       done,
  output logic [udf_pkg::DIST_W-1:0] median
);
  import udf_pkg::*;

  localparam int IDX_W = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
  localparam int CNT_W = $clog2(MEDIAN_DEPTH + 1);

  typedef enum logic {M_IDLE, M_SCAN} mstate_t;

  mstate_t           state;
  logic [DIST_W-1:0] mem [MEDIAN_DEPTH];
  logic [DIST_W-1:0] rd_a;
  logic [DIST_W-1:0] rd_b;
  logic [IDX_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  fill;
  logic [IDX_W-1:0]  ai;
  logic [IDX_W-1:0]  aj;
  logic              iss_on;
  logic [IDX_W-1:0]  pi;
  logic [IDX_W-1:0]  pj;
  logic              pv;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  last_idx;
  logic [CNT_W-1:0]  half;
  logic              less;
  logic [CNT_W-1:0]  cnt_tot;

  always_comb begin
    last_idx = IDX_W'(fill - CNT_W'(1));
    half     = fill >> 1;
    less     = (rd_b < rd_a) || ((rd_b == rd_a) && (pj < pi));
    cnt_tot  = cnt + CNT_W'(less);
  end

  always_ff @(posedge clk) begin
    if ((state == M_IDLE) && start) begin
      mem[wr_idx] <= din;
    end
    rd_a <= mem[ai];
    rd_b <= mem[aj];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= M_IDLE;
      wr_idx <= '0;
      fill   <= '0;
      iss_on <= 1'b0;
      pv     <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          pv <= 1'b0;
          if (start) begin
            wr_idx <= (wr_idx == IDX_W'(MEDIAN_DEPTH - 1)) ? '0 : wr_idx + IDX_W'(1);
            if (fill != CNT_W'(MEDIAN_DEPTH)) begin
              fill <= fill + CNT_W'(1);
            end
            ai     <= '0;
            aj     <= '0;
            cnt    <= '0;
            iss_on <= 1'b1;
            state  <= M_SCAN;
          end
        end
        M_SCAN: begin
          pi <= ai;
          pj <= aj;
          pv <= iss_on;
          if (iss_on) begin
            if (aj == last_idx) begin
              aj <= '0;
              ai <= ai + IDX_W'(1);
              if (ai == last_idx) begin
                iss_on <= 1'b0;
              end
            end else begin
              aj <= aj + IDX_W'(1);
            end
          end
          if (pv) begin
            if (pj == last_idx) begin
              cnt <= '0;
              if (cnt_tot == half) begin
                median <= rd_a;
                done   <= 1'b1;
                iss_on <= 1'b0;
                state  <= M_IDLE;
              end
            end else begin
              cnt <= cnt_tot;
            end
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  `UDF_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= CNT_W'(MEDIAN_DEPTH))
  `UDF_ASSERT_IMP(a_wr_bound, clk, rst, 1'b1, wr_idx <= IDX_W'(MEDIAN_DEPTH - 1))
  `UDF_ASSERT_IMP(a_start_idle, clk, rst, start, state == M_IDLE)
  `UDF_ASSERT_IMP(a_done_from_scan, clk, rst, done, (state == M_IDLE) && $past(state == M_SCAN))

endmodule

// ----- rtl/core/ultrasonic_distance_filter_unit.sv -----
// Top level of the ultrasonic distance filter: frame checks, median, spike gate, rounding.
// Bytes from the sensor UART enter one at a time; after each accepted byte the unit
// passes its check state and takes no new byte until it is back in idle. The fourth
// byte of a frame yields one result: an error frame goes straight from the check to
// the emit state, while a good frame runs the median search, which ranks each
// candidate against every one of the n valid window entries on one shared comparator
// and stops at the entry of median rank; that result then passes the spike gate and
// rounding before it is emitted. A finished result waits in an output register, and
// bytes are taken again while it waits. Configuration writes are taken at any time.
`include "ultrasonic_distance_filter_unit_assert.svh"
module ultrasonic_distance_filter_unit #(
  parameter int MEDIAN_DEPTH = udf_pkg::MEDIAN_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [udf_pkg::BYTE_W-1:0]     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [udf_pkg::STATUS_W-1:0]   status,
  output logic [udf_pkg::DIST_W-1:0]     distance_mm,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [udf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [udf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import udf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_MEDIAN, S_GATE, S_ROUND, S_EMIT} state_t;

  state_t                state;
  logic [HEIGHT_W-1:0]   tank_height;
  logic [OFFSET_W-1:0]   sensor_offset;
  logic [SPIKE_W-1:0]    spike_max_mm;
  logic [HOLDOFF_W-1:0]  spike_holdoff;
  logic [DIST_W-1:0]     last_filtered;
  logic [HOLDOFF_W-1:0]  spike_run;
  logic [STATUS_W-1:0]   res_status;
  logic [DIST_W-1:0]     gate_value;
  logic [PROD_W-1:0]     prod;
  frm_res_t              frm;
  logic                  med_start;
  logic                  med_done;
  logic [DIST_W-1:0]     med_value;
  logic                  in_acc;
  logic [DIST_W-1:0]     delta;
  logic [UPPER_W-1:0]    round_in;
  logic [DIST_W-1:0]     quot;
  logic [DIST_W-1:0]     rounded;
  logic                  out_free;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign med_start = (state == S_CHECK) && frm.valid && frm.csum_ok && frm.range_ok;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    delta    = (med_value > last_filtered) ? med_value - last_filtered
                                           : last_filtered - med_value;
    round_in = UPPER_W'(gate_value) + UPPER_W'(ROUND_STEP - 1);
    quot     = DIST_W'(prod >> RECIP_SHIFT);
    rounded  = (quot << 3) + (quot << 1);
  end

  udf_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (in_acc),
    .rx_byte       (rx_byte),
    .tank_height   (tank_height),
    .sensor_offset (sensor_offset),
    .frm           (frm)
  );

  udf_median #(
    .MEDIAN_DEPTH (MEDIAN_DEPTH)
  ) u_median (
    .clk    (clk),
    .rst    (rst),
    .start  (med_start),
    .din    (frm.distance),
    .done   (med_done),
    .median (med_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tank_height   <= HEIGHT_RST;
      sensor_offset <= OFFSET_RST;
      spike_max_mm  <= SPIKE_RST;
      spike_holdoff <= HOLDOFF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TANK_HEIGHT:   tank_height   <= cfg_data[HEIGHT_W-1:0];
        REG_SENSOR_OFFSET: sensor_offset <= cfg_data[OFFSET_W-1:0];
        REG_SPIKE_MAX:     spike_max_mm  <= cfg_data[SPIKE_W-1:0];
        REG_SPIKE_HOLDOFF: spike_holdoff <= cfg_data[HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      last_filtered <= '0;
      spike_run     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && !((state == S_EMIT) && out_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!frm.valid) begin
            state <= S_IDLE;
          end else if (!frm.csum_ok) begin
            res_status <= ST_CSUM;
            prod       <= '0;
            state      <= S_EMIT;
          end else if (!frm.range_ok) begin
            res_status <= ST_RANGE;
            prod       <= '0;
            state      <= S_EMIT;
          end else begin
            state <= S_MEDIAN;
          end
        end
        S_MEDIAN: begin
          if (med_done) begin
            state <= S_GATE;
          end
        end
        S_GATE: begin
          res_status <= ST_OK;
          gate_value <= med_value;
          if (last_filtered == '0) begin
            last_filtered <= med_value;
          end else if (spike_run >= spike_holdoff) begin
            last_filtered <= med_value;
            spike_run     <= '0;
          end else if (delta > spike_max_mm) begin
            spike_run  <= spike_run + HOLDOFF_W'(1);
            gate_value <= last_filtered;
            res_status <= ST_SPIKE;
          end else begin
            last_filtered <= med_value;
            spike_run     <= '0;
          end
          state <= S_ROUND;
        end
        S_ROUND: begin
          prod  <= PROD_W'(round_in) * PROD_W'(RECIP_MUL);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            distance_mm <= rounded;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `UDF_ASSERT_IMP(a_done_in_median, clk, rst, med_done, state == S_MEDIAN)
  `UDF_ASSERT_IMP(a_frame_in_check, clk, rst, frm.valid, state == S_CHECK)
  `UDF_ASSERT_NEXT(a_emit_loads, clk, rst, (state == S_EMIT) && out_free, out_valid)
  `UDF_ASSERT_NEXT(a_first_sample_ok, clk, rst, (state == S_GATE) && (last_filtered == '0), res_status == ST_OK)

endmodule
